// ===== hdl/char_lcd_parallel_bus_controller_macros.svh =====
// assertion macros used by the display bus controller sequencer
`ifndef CHAR_LCD_PARALLEL_BUS_CONTROLLER_MACROS_SVH
`define CHAR_LCD_PARALLEL_BUS_CONTROLLER_MACROS_SVH

// condition holds on every clock outside reset
`define CLPB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("clpb assertion failed");

// consequence holds in the cycle after the antecedent
`define CLPB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clpb assertion failed");

`endif

// ===== hdl/clpb_pkg.sv =====
package clpb_pkg;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_COMMAND = 3'd1;
    localparam logic [2:0] MODE_CHAR    = 3'd2;
    localparam logic [2:0] MODE_GOTO    = 3'd3;
    localparam logic [2:0] MODE_INIT    = 3'd4;
    localparam logic [2:0] MODE_CLEAR   = 3'd5;

    localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
    localparam logic [1:0] CFG_GAP          = 2'd1;
    localparam logic [1:0] CFG_POWER_UP     = 2'd2;

    localparam logic [7:0]  CFG_ENABLE_PULSE_RST = 8'd1;
    localparam logic [15:0] CFG_GAP_RST          = 16'd50;
    localparam logic [15:0] CFG_POWER_UP_RST     = 16'd40000;

    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] DDRAM_SET_ADDR = 8'h80;
    localparam logic [6:0] ROW2_OFFSET    = 7'h40;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic [1:0] row;
        logic [5:0] column;
        logic       busy_line;
    } req_t;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_rw;
        logic       pin_enable;
        logic [7:0] bus_out;
        logic       bus_drive;
        logic       ready_res;
        logic       rejected;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  enable_pulse_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] power_up_ticks;
    } cfg_t;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       enable;
        logic [7:0] bus;
        logic       drive;
    } pins_t;

    // init byte sequence, index taken modulo five
    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = 8'h38;
            3'd1:    b = 8'h38;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h04;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h38;
            3'd6:    b = 8'h38;
            3'd7:    b = 8'h0C;
            default: b = 8'h38;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/clpb_sequencer.sv =====
`include "char_lcd_parallel_bus_controller_macros.svh"

module clpb_sequencer
    import clpb_pkg::*;
#(
    parameter int ROW_CLEAR_COUNT = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t item,
    input  cfg_t cfg,
    output rsp_t result
);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_POWER      = 4'd1;
    localparam logic [3:0] PH_INIT_HIGH  = 4'd2;
    localparam logic [3:0] PH_INIT_GAP   = 4'd3;
    localparam logic [3:0] PH_POLL_LOW   = 4'd4;
    localparam logic [3:0] PH_POLL_HIGH  = 4'd5;
    localparam logic [3:0] PH_WRITE_HIGH = 4'd6;

    localparam logic [3:0] CLEAR_COUNT = 4'(ROW_CLEAR_COUNT);

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  pending_byte_reg, pending_byte_next;
    logic        pending_is_data_reg, pending_is_data_next;
    logic [2:0]  init_step_reg, init_step_next;
    logic [3:0]  spaces_left_reg, spaces_left_next;
    pins_t       pins_reg, pins_next;

    logic [15:0] timer_dec;
    logic [15:0] pulse_ticks;
    logic [6:0]  goto_addr;
    logic        is_request;
    logic        rejected;
    pins_t       poll_low_pins;

    assign timer_dec   = (timer_reg != 16'd0) ? (timer_reg - 16'd1) : 16'd0;
    assign pulse_ticks = {8'd0, cfg.enable_pulse_ticks};
    assign goto_addr   = (item.row == 2'd1) ? ({1'b0, item.column} - 7'd1)
                                            : ({1'b0, item.column} - 7'd1 + ROW2_OFFSET);
    assign is_request  = (item.mode == MODE_COMMAND) || (item.mode == MODE_CHAR)
                      || (item.mode == MODE_GOTO) || (item.mode == MODE_INIT)
                      || (item.mode == MODE_CLEAR);
    assign rejected    = is_request && (phase_reg != PH_IDLE);
    assign poll_low_pins = '{rs: 1'b0, rw: 1'b1, enable: 1'b0, bus: 8'd0, drive: 1'b0};

    always_comb
    begin
        phase_next           = phase_reg;
        timer_next           = timer_reg;
        pending_byte_next    = pending_byte_reg;
        pending_is_data_next = pending_is_data_reg;
        init_step_next       = init_step_reg;
        spaces_left_next     = spaces_left_reg;
        pins_next            = pins_reg;

        if (item.mode == MODE_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                timer_next = timer_dec;
                if (timer_dec == 16'd0)
                begin
                    case (phase_reg)
                        PH_POWER:
                        begin
                            init_step_next = 3'd0;
                            pins_next  = '{rs: 1'b0, rw: 1'b0, enable: 1'b1,
                                           bus: init_byte(3'd0), drive: 1'b1};
                            timer_next = pulse_ticks;
                            phase_next = PH_INIT_HIGH;
                        end
                        PH_INIT_HIGH:
                        begin
                            pins_next.enable = 1'b0;
                            if (init_step_reg >= 3'd4)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                timer_next = cfg.gap_ticks;
                                phase_next = PH_INIT_GAP;
                            end
                        end
                        PH_INIT_GAP:
                        begin
                            init_step_next = init_step_reg + 3'd1;
                            pins_next  = '{rs: 1'b0, rw: 1'b0, enable: 1'b1,
                                           bus: init_byte(init_step_reg + 3'd1),
                                           drive: 1'b1};
                            timer_next = pulse_ticks;
                            phase_next = PH_INIT_HIGH;
                        end
                        PH_POLL_LOW:
                        begin
                            pins_next  = '{rs: 1'b0, rw: 1'b1, enable: 1'b1,
                                           bus: 8'd0, drive: 1'b0};
                            timer_next = pulse_ticks;
                            phase_next = PH_POLL_HIGH;
                        end
                        PH_POLL_HIGH:
                        begin
                            timer_next = pulse_ticks;
                            if (item.busy_line)
                            begin
                                pins_next  = poll_low_pins;
                                phase_next = PH_POLL_LOW;
                            end
                            else
                            begin
                                pins_next  = '{rs: pending_is_data_reg, rw: 1'b0,
                                               enable: 1'b1, bus: pending_byte_reg,
                                               drive: 1'b1};
                                phase_next = PH_WRITE_HIGH;
                            end
                        end
                        PH_WRITE_HIGH:
                        begin
                            pins_next.enable = 1'b0;
                            if (spaces_left_reg > 4'd1)
                            begin
                                // next space of a row clear
                                spaces_left_next = spaces_left_reg - 4'd1;
                                pins_next        = poll_low_pins;
                                timer_next       = pulse_ticks;
                                phase_next       = PH_POLL_LOW;
                            end
                            else
                            begin
                                spaces_left_next = 4'd0;
                                phase_next       = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
        else if (is_request && (phase_reg == PH_IDLE))
        begin
            case (item.mode)
                MODE_INIT:
                begin
                    init_step_next = 3'd0;
                    timer_next     = cfg.power_up_ticks;
                    phase_next     = PH_POWER;
                end
                default:
                begin
                    case (item.mode)
                        MODE_COMMAND:
                        begin
                            pending_byte_next    = item.data_byte;
                            pending_is_data_next = 1'b0;
                            spaces_left_next     = 4'd0;
                        end
                        MODE_CHAR:
                        begin
                            pending_byte_next    = item.data_byte;
                            pending_is_data_next = 1'b1;
                            spaces_left_next     = 4'd0;
                        end
                        MODE_GOTO:
                        begin
                            pending_byte_next    = DDRAM_SET_ADDR | {1'b0, goto_addr};
                            pending_is_data_next = 1'b0;
                            spaces_left_next     = 4'd0;
                        end
                        default:
                        begin
                            pending_byte_next    = SPACE_CHAR;
                            pending_is_data_next = 1'b1;
                            spaces_left_next     = CLEAR_COUNT;
                        end
                    endcase
                    pins_next  = poll_low_pins;
                    timer_next = pulse_ticks;
                    phase_next = PH_POLL_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            timer_reg           <= 16'd0;
            pending_byte_reg    <= 8'd0;
            pending_is_data_reg <= 1'b0;
            init_step_reg       <= 3'd0;
            spaces_left_reg     <= 4'd0;
            pins_reg            <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            timer_reg           <= timer_next;
            pending_byte_reg    <= pending_byte_next;
            pending_is_data_reg <= pending_is_data_next;
            init_step_reg       <= init_step_next;
            spaces_left_reg     <= spaces_left_next;
            pins_reg            <= pins_next;
        end
    end

    assign result = '{pin_rs:     pins_next.rs,
                      pin_rw:     pins_next.rw,
                      pin_enable: pins_next.enable,
                      bus_out:    pins_next.bus,
                      bus_drive:  pins_next.drive,
                      ready_res:  (phase_next == PH_IDLE),
                      rejected:   rejected};

    `CLPB_ASSERT_ALWAYS(a_released_bus_zero, pins_reg.drive || (pins_reg.bus == 8'd0))
    `CLPB_ASSERT_ALWAYS(a_idle_enable_low, (phase_reg != PH_IDLE) || !pins_reg.enable)
    `CLPB_ASSERT_ALWAYS(a_read_not_driven, !pins_reg.rw || !pins_reg.drive)
    `CLPB_ASSERT_NEXT(a_reject_holds_state, step && rejected,
                      $stable(phase_reg) && $stable(timer_reg) && $stable(pins_reg))

endmodule

// ===== hdl/char_lcd_parallel_bus_controller.sv =====
// latency: a result is valid the cycle after its request is accepted
// throughput: one request per cycle; the output register frees the input side
// whenever the held result is taken in the same cycle
// reset: sequencer idle, pins low with the bus released, no result pending,
// configuration back to 1 / 50 / 40000 ticks
module char_lcd_parallel_bus_controller
    import clpb_pkg::*;
#(
    parameter int ROW_CLEAR_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic step;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign step      = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_pulse_ticks <= CFG_ENABLE_PULSE_RST;
            cfg_reg.gap_ticks          <= CFG_GAP_RST;
            cfg_reg.power_up_ticks     <= CFG_POWER_UP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE_PULSE: cfg_reg.enable_pulse_ticks <= cfg_data[7:0];
                CFG_GAP:          cfg_reg.gap_ticks          <= cfg_data;
                CFG_POWER_UP:     cfg_reg.power_up_ticks     <= cfg_data;
                default:          ;
            endcase
        end
    end

    clpb_sequencer #(
        .ROW_CLEAR_COUNT (ROW_CLEAR_COUNT)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (req),
        .cfg    (cfg_reg),
        .result (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            rsp_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== dv/tb_char_lcd_parallel_bus_controller.sv =====
module tb_char_lcd_parallel_bus_controller;
    import clpb_pkg::*;

    localparam int CLEAR_SPACES = 8;
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_POWER,
        SQ_INIT_HIGH,
        SQ_INIT_GAP,
        SQ_POLL_LOW,
        SQ_POLL_HIGH,
        SQ_WRITE_HIGH
    } seq_phase_e;

    class lcd_pin_scoreboard;
        rsp_t        expected_pins[$];
        int          errors;
        int          checked;
        logic [7:0]  pulse_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] power_ticks;
        seq_phase_e  phase;
        logic [15:0] timer;
        logic [7:0]  pend_byte;
        logic        pend_is_char;
        logic [2:0]  init_idx;
        logic [3:0]  spaces_left;
        pins_t       pins;

        function new();
            errors       = 0;
            checked      = 0;
            pulse_ticks  = CFG_ENABLE_PULSE_RST;
            gap_ticks    = CFG_GAP_RST;
            power_ticks  = CFG_POWER_UP_RST;
            phase        = SQ_IDLE;
            timer        = '0;
            pend_byte    = '0;
            pend_is_char = 1'b0;
            init_idx     = '0;
            spaces_left  = '0;
            pins         = '0;
        endfunction

        function void set_config(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_ENABLE_PULSE: pulse_ticks = value[7:0];
                CFG_GAP:          gap_ticks = value;
                CFG_POWER_UP:     power_ticks = value;
                default:          ;
            endcase
        endfunction

        function void drive_pins(logic rs, logic rw, logic en, logic [7:0] bus, logic drive);
            pins.rs     = rs;
            pins.rw     = rw;
            pins.enable = en;
            pins.bus    = drive ? bus : 8'h00;
            pins.drive  = drive;
        endfunction

        function logic [7:0] init_code(logic [2:0] idx);
            logic [2:0] k;
            k = idx % 3'd5;
            case (k)
                3'd0, 3'd1: return 8'h38;
                3'd2:       return 8'h0C;
                3'd3:       return 8'h04;
                default:    return 8'h01;
            endcase
        endfunction

        function void start_poll();
            drive_pins(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            timer = {8'h00, pulse_ticks};
            phase = SQ_POLL_LOW;
        endfunction

        function void start_init_byte();
            drive_pins(1'b0, 1'b0, 1'b1, init_code(init_idx), 1'b1);
            timer = {8'h00, pulse_ticks};
            phase = SQ_INIT_HIGH;
        endfunction

        function void begin_write(logic [7:0] value, logic is_char, logic [3:0] count);
            pend_byte    = value;
            pend_is_char = is_char;
            spaces_left  = count;
            start_poll();
        endfunction

        function void advance_tick(logic busy);
            if (phase == SQ_IDLE)
                return;
            if (timer != 0)
                timer--;
            if (timer != 0)
                return;
            case (phase)
                SQ_POWER:
                begin
                    init_idx = '0;
                    start_init_byte();
                end
                SQ_INIT_HIGH:
                begin
                    pins.enable = 1'b0;
                    if (init_idx >= 3'd4)
                        phase = SQ_IDLE;
                    else
                    begin
                        timer = gap_ticks;
                        phase = SQ_INIT_GAP;
                    end
                end
                SQ_INIT_GAP:
                begin
                    init_idx = init_idx + 3'd1;
                    start_init_byte();
                end
                SQ_POLL_LOW:
                begin
                    drive_pins(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
                    timer = {8'h00, pulse_ticks};
                    phase = SQ_POLL_HIGH;
                end
                SQ_POLL_HIGH:
                begin
                    // busy flag still set: strobe the read again
                    if (busy)
                        start_poll();
                    else
                    begin
                        drive_pins(pend_is_char, 1'b0, 1'b1, pend_byte, 1'b1);
                        timer = {8'h00, pulse_ticks};
                        phase = SQ_WRITE_HIGH;
                    end
                end
                SQ_WRITE_HIGH:
                begin
                    pins.enable = 1'b0;
                    if (spaces_left > 4'd1)
                    begin
                        spaces_left--;
                        start_poll();
                    end
                    else
                    begin
                        spaces_left = '0;
                        phase = SQ_IDLE;
                    end
                end
                default: phase = SQ_IDLE;
            endcase
        endfunction

        function void note_request(req_t r);
            rsp_t       want;
            logic       rej;
            logic [6:0] addr;
            rej = 1'b0;
            case (r.mode)
                MODE_TICK: advance_tick(r.busy_line);
                MODE_COMMAND, MODE_CHAR, MODE_GOTO, MODE_INIT, MODE_CLEAR:
                begin
                    if (phase != SQ_IDLE)
                        rej = 1'b1;
                    else
                    begin
                        case (r.mode)
                            MODE_COMMAND: begin_write(r.data_byte, 1'b0, 4'd0);
                            MODE_CHAR:    begin_write(r.data_byte, 1'b1, 4'd0);
                            MODE_GOTO:
                            begin
                                // column 0 wraps around the 7-bit address
                                if (r.row == 2'd1)
                                    addr = {1'b0, r.column} - 7'd1;
                                else
                                    addr = ROW2_OFFSET + {1'b0, r.column} - 7'd1;
                                begin_write(DDRAM_SET_ADDR | {1'b0, addr}, 1'b0, 4'd0);
                            end
                            MODE_INIT:
                            begin
                                init_idx = '0;
                                timer    = power_ticks;
                                phase    = SQ_POWER;
                            end
                            default: begin_write(SPACE_CHAR, 1'b1, CLEAR_SPACES[3:0]);
                        endcase
                    end
                end
                default: ;
            endcase
            want.pin_rs     = pins.rs;
            want.pin_rw     = pins.rw;
            want.pin_enable = pins.enable;
            want.bus_out    = pins.bus;
            want.bus_drive  = pins.drive;
            want.ready_res  = (phase == SQ_IDLE);
            want.rejected   = rej;
            expected_pins.push_back(want);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_pins.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_pins.pop_front();
            checked++;
            compare_field("pin_rs", 8'(want.pin_rs), 8'(got.pin_rs));
            compare_field("pin_rw", 8'(want.pin_rw), 8'(got.pin_rw));
            compare_field("pin_enable", 8'(want.pin_enable), 8'(got.pin_enable));
            compare_field("bus_out", want.bus_out, got.bus_out);
            compare_field("bus_drive", 8'(want.bus_drive), 8'(got.bus_drive));
            compare_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
            compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_ENABLE_PULSE;
    logic [15:0] cfg_data = '0;

    int idle_pct = 34;
    lcd_pin_scoreboard sb = new();

    char_lcd_parallel_bus_controller #(
        .ROW_CLEAR_COUNT (CLEAR_SPACES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic req_t make_req(logic [2:0] mode, logic [7:0] value, logic [1:0] row,
                                      logic [5:0] column, logic busy);
        req_t r;
        r.mode      = mode;
        r.data_byte = value;
        r.row       = row;
        r.column    = column;
        r.busy_line = busy;
        return r;
    endfunction

    function automatic req_t random_item();
        req_t r;
        int   pick;
        r = make_req(MODE_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)),
                     6'($urandom_range(63)), 1'($urandom_range(1)));
        pick = $urandom_range(99);
        if (sb.phase == SQ_IDLE)
        begin
            if (pick < 8)
                r.mode = MODE_TICK;
            else if (pick < 14)
                r.mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
            else if (pick < 38)
                r.mode = MODE_COMMAND;
            else if (pick < 58)
                r.mode = MODE_CHAR;
            else if (pick < 78)
                r.mode = MODE_GOTO;
            else if (pick < 90)
                r.mode = MODE_CLEAR;
            else
                r.mode = MODE_INIT;
        end
        else
        begin
            // mostly ticks that walk the sequencer, a few requests it must refuse
            if (pick < 6)
                r.mode = 3'($urandom_range(MODE_CLEAR, MODE_COMMAND));
            else if (pick < 9)
                r.mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
            else if (sb.phase == SQ_POLL_HIGH)
                r.busy_line = ($urandom_range(99) < 35);
        end
        return r;
    endfunction

    task automatic send_item(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic run_to_idle(input int busy_pct);
        req_t r;
        while (sb.phase != SQ_IDLE)
        begin
            r = make_req(MODE_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)),
                         6'($urandom_range(63)), 1'($urandom_range(1)));
            if (sb.phase == SQ_POLL_HIGH)
                r.busy_line = ($urandom_range(99) < busy_pct);
            send_item(r);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.expected_pins.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] pulse, input logic [15:0] gap,
                              input logic [15:0] power);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENABLE_PULSE;
        cfg_data  <= {8'h00, pulse};
        @(posedge clk);
        sb.set_config(CFG_ENABLE_PULSE, {8'h00, pulse});
        cfg_index <= CFG_GAP;
        cfg_data  <= gap;
        @(posedge clk);
        sb.set_config(CFG_GAP, gap);
        cfg_index <= CFG_POWER_UP;
        cfg_data  <= power;
        @(posedge clk);
        sb.set_config(CFG_POWER_UP, power);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] pulse, input logic [15:0] gap,
                             input logic [15:0] power, input int n);
        drain();
        write_regs(pulse, gap, power);
        repeat (n) send_item(random_item());
        run_to_idle(35);
    endtask

    // result side: random stalls plus one long hold-off so the request side backs up
    initial
    begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
            if (!held && sb.checked == 60)
            begin
                hold_left = 300;
                held = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial
    begin : watchdog
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: idle tick, spare modes, command, char, goto and clear requests
        send_item(make_req(MODE_TICK, 8'hFF, 2'd3, 6'd63, 1'b1));
        send_item(make_req(MODE_SPARE_LO, 8'h00, 2'd0, 6'd0, 1'b0));
        send_item(make_req(MODE_SPARE_HI, 8'hFF, 2'd3, 6'd63, 1'b1));
        send_item(make_req(MODE_COMMAND, 8'h00, 2'd0, 6'd0, 1'b0));
        run_to_idle(0);
        send_item(make_req(MODE_CHAR, 8'hFF, 2'd1, 6'd1, 1'b0));
        send_item(make_req(MODE_COMMAND, 8'h01, 2'd1, 6'd1, 1'b0));
        run_to_idle(60);
        send_item(make_req(MODE_GOTO, 8'h00, 2'd1, 6'd1, 1'b0));
        run_to_idle(0);
        send_item(make_req(MODE_GOTO, 8'h00, 2'd2, 6'd40, 1'b0));
        run_to_idle(0);
        send_item(make_req(MODE_GOTO, 8'hFF, 2'd0, 6'd0, 1'b1));
        run_to_idle(30);
        send_item(make_req(MODE_GOTO, 8'hFF, 2'd3, 6'd63, 1'b1));
        run_to_idle(0);
        send_item(make_req(MODE_GOTO, 8'h00, 2'd1, 6'd0, 1'b0));
        run_to_idle(0);
        send_item(make_req(MODE_CLEAR, 8'h00, 2'd0, 6'd0, 1'b0));
        send_item(make_req(MODE_CLEAR, 8'h00, 2'd0, 6'd0, 1'b0));
        run_to_idle(30);

        // short init timing so the sequence stays brief
        drain();
        write_regs(8'd1, 16'd2, 16'd3);
        send_item(make_req(MODE_INIT, 8'h00, 2'd0, 6'd0, 1'b0));
        send_item(make_req(MODE_GOTO, 8'h00, 2'd1, 6'd1, 1'b0));
        run_to_idle(0);
        send_item(make_req(MODE_CHAR, 8'h41, 2'd1, 6'd1, 1'b0));
        run_to_idle(0);

        run_phase(8'd1, 16'd0, 16'd0, 35);
        run_phase(8'd2, 16'd3, 16'd7, 35);

        // longer strobes, with no idling on either side
        drain();
        write_regs(8'd3, 16'd2, 16'd5);
        idle_pct = 0;
        send_item(make_req(MODE_INIT, 8'h00, 2'd0, 6'd0, 1'b0));
        run_to_idle(0);
        send_item(make_req(MODE_CLEAR, 8'hFF, 2'd3, 6'd63, 1'b1));
        run_to_idle(40);
        idle_pct = 34;

        run_phase(8'($urandom_range(4, 1)), 16'($urandom_range(6)), 16'($urandom_range(20)),
                  35);
        run_phase(8'd3, 16'd1, 16'd2, 35);

        drain();
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/clpb_pkg.sv
hdl/clpb_sequencer.sv
hdl/char_lcd_parallel_bus_controller.sv
dv/tb_char_lcd_parallel_bus_controller.sv
